// ----- rtl/cbt_pkg.sv -----
// Package for the calculator-charset byte transcoder.
// Holds the mode codes, the translation record and the Greek code point table.
// No dependencies.
`default_nettype none

package cbt_pkg;

  localparam int ByteW = 8;
  localparam int ModeW = 2;
  localparam int AddrW = 3;
  localparam int DataW = 32;

  localparam logic [ModeW-1:0] MODE_ASCII  = 2'd0;
  localparam logic [ModeW-1:0] MODE_LATIN1 = 2'd1;
  localparam logic [ModeW-1:0] MODE_UTF8   = 2'd2;

  localparam logic [AddrW-3:0] REG_ENCODING_MODE = 1'b0;

  localparam logic [ByteW-1:0] UNDERSCORE  = 8'h5F;
  localparam logic [ByteW-1:0] GREEK_FIRST = 8'h80;
  localparam logic [ByteW-1:0] GREEK_END   = 8'h95;
  localparam logic [ByteW-1:0] HIGH_FIRST  = 8'hA0;

  // One translated input: no, one or two output bytes.
  typedef struct packed {
    logic [1:0]       count;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic             term;
  } xlat_t;

  // Greek code points for source bytes 0x80 to 0x94, indexed from 0x80.
  function automatic logic [10:0] greek_point(input logic [4:0] idx);
    logic [10:0] cp;
    begin
      unique case (idx)
        5'd0:    cp = 11'h3B1;
        5'd1:    cp = 11'h3B2;
        5'd2:    cp = 11'h393;
        5'd3:    cp = 11'h3B3;
        5'd4:    cp = 11'h394;
        5'd5:    cp = 11'h3B4;
        5'd6:    cp = 11'h3B5;
        5'd7:    cp = 11'h3B6;
        5'd8:    cp = 11'h3B8;
        5'd9:    cp = 11'h3BB;
        5'd10:   cp = 11'h3BE;
        5'd11:   cp = 11'h3A0;
        5'd12:   cp = 11'h3C0;
        5'd13:   cp = 11'h3C1;
        5'd14:   cp = 11'h3A3;
        5'd15:   cp = 11'h3C3;
        5'd16:   cp = 11'h3C4;
        5'd17:   cp = 11'h3D5;
        5'd18:   cp = 11'h3A8;
        5'd19:   cp = 11'h3A9;
        5'd20:   cp = 11'h3C9;
        default: cp = 11'h05F;
      endcase
      return cp;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cbt_translate.sv -----
// Combinational translation of one source byte under the current mode.
// Depends on cbt_pkg.
`default_nettype none

module cbt_translate (
  input  wire logic [cbt_pkg::ByteW-1:0] char_byte,
  input  wire logic [cbt_pkg::ModeW-1:0] mode,
  output cbt_pkg::xlat_t                 xlat
);
  import cbt_pkg::*;

  logic [10:0] cp;

  always_comb begin
    xlat = '0;
    cp   = {3'd0, char_byte};
    if (char_byte >= GREEK_FIRST && char_byte < GREEK_END) begin
      cp = greek_point(char_byte[4:0]);
    end else if (char_byte >= GREEK_END && char_byte < HIGH_FIRST) begin
      cp = {3'd0, UNDERSCORE};
    end
    if (mode == MODE_ASCII || mode == MODE_LATIN1 || mode == MODE_UTF8) begin
      xlat.count = 2'd1;
    end
    if (char_byte == '0) begin
      xlat.term = 1'b1;
    end else begin
      unique case (mode)
        MODE_ASCII: begin
          xlat.b0 = char_byte[7] ? UNDERSCORE : char_byte;
        end
        MODE_LATIN1: begin
          xlat.b0 = (char_byte >= GREEK_FIRST && char_byte < HIGH_FIRST)
                    ? UNDERSCORE : char_byte;
        end
        MODE_UTF8: begin
          if (cp < 11'h080) begin
            xlat.b0 = cp[7:0];
          end else begin
            xlat.count = 2'd2;
            xlat.b0    = {3'b110, cp[10:6]};
            xlat.b1    = {2'b10, cp[5:0]};
          end
        end
        default: begin
          xlat.count = 2'd0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/charset_byte_transcoder.sv -----
// A request is held in the input register once accepted, moves into the result register
// when that is free, and its first output byte is offered from the result register;
// throughput is one request per cycle for one-byte results while out_ready stays high, and
// where UTF-8 gives two bytes the single output port offers them one after the other.
// Synchronous active-high reset empties both stages and sets encoding_mode to Latin1.
// Depends on cbt_pkg and cbt_translate.
`default_nettype none

module charset_byte_transcoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Byte request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cbt_pkg::ByteW-1:0]   char_byte,
  // Output byte channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cbt_pkg::ByteW-1:0]        out_byte,
  output logic                             last_of_run,
  output logic                             string_end,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cbt_pkg::AddrW-1:0]   paddr,
  input  wire logic [cbt_pkg::DataW-1:0]   pwdata,
  output logic [cbt_pkg::DataW-1:0]        prdata,
  output logic                             pready
);
  import cbt_pkg::*;

  // Configuration register. The word index sits above the byte offset.
  logic [ModeW-1:0] mode;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_LATIN1;
    end else if (cfg_write && paddr[AddrW-1:2] == REG_ENCODING_MODE) begin
      mode <= pwdata[ModeW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[AddrW-1:2] == REG_ENCODING_MODE) begin
      prdata = {{(DataW-ModeW){1'b0}}, mode};
    end
  end

  // Input register: holds the accepted request byte until the result register is free.
  logic             req_valid;
  logic [ByteW-1:0] req_byte;

  // Result register: the translated bytes and which of them is on offer.
  logic             res_valid;
  logic             res_second;
  xlat_t            res;
  xlat_t            xlat;

  logic             res_done;
  logic             move;
  logic             in_fire;

  cbt_translate u_translate (
    .char_byte (req_byte),
    .mode      (mode),
    .xlat      (xlat)
  );

  // The result register frees when its last byte is taken, so a request moves
  // forward in that same cycle and the input register can take the next one.
  assign res_done = out_ready && last_of_run;
  assign move     = req_valid && (!res_valid || res_done);
  assign in_ready = !req_valid || move;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_fire) begin
      req_valid <= 1'b1;
    end else if (move) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_byte <= char_byte;
    end
  end

  // A request in the unused mode translates to no bytes and simply vanishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      res_second <= 1'b0;
    end else if (move) begin
      res_valid  <= (xlat.count != 2'd0);
      res_second <= 1'b0;
    end else if (res_valid && out_ready) begin
      if (last_of_run) begin
        res_valid  <= 1'b0;
        res_second <= 1'b0;
      end else begin
        res_second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res <= xlat;
    end
  end

  assign out_valid   = res_valid;
  assign out_byte    = res_second ? res.b1 : res.b0;
  assign last_of_run = (res.count != 2'd2) || res_second;
  assign string_end  = res.term;

`ifndef NO_ASSERTIONS
  // Only a two-byte result ever advances to its second byte.
  a_second_needs_two: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_second) |-> (res.count == 2'd2))
    else $error("second byte offered for a one-byte result");

  // The terminator is always a single zero byte.
  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && string_end) |-> (last_of_run && out_byte == '0))
    else $error("malformed string terminator");

  // The first byte of a pair, once taken, is followed by the second byte.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_ready && !last_of_run) |=> (res_valid && res_second))
    else $error("second byte of a pair lost");

  // Reset leaves the mode at Latin1.
  a_reset_mode: assert property (@(posedge clk)
    rst |=> (mode == MODE_LATIN1))
    else $error("mode not Latin1 after reset");
`endif

endmodule

`default_nettype wire
